// File: rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants for the buddy page allocator
// no dependencies

package bpa_pkg;

  localparam int PAGE_INDEX_BITS_DEF = 16;
  localparam int NUM_LEVELS_DEF      = 17;

  localparam int ACTION_W  = 2;
  localparam int ORDER_W   = 5;
  localparam int PAGE_W    = PAGE_INDEX_BITS_DEF;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = PAGE_INDEX_BITS_DEF + 1;
  localparam int CFG_W     = PAGE_INDEX_BITS_DEF + 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [ACTION_W-1:0] ACT_INIT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ORDER_W-1:0]  order;
    logic [ORDER_W-1:0]  align_log2;
    logic [PAGE_W-1:0]   page;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   granted_page;
    logic [COUNT_W-1:0]  used_pages;
  } rsp_t;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LATCH,
    OP_CLEAR_START,
    OP_SWEEP,
    OP_CARVE_INIT,
    OP_CARVE_LVL,
    OP_PUSH1,
    OP_PUSH2,
    OP_PUSH2_ADV,
    OP_ALLOC_START,
    OP_LOAD_HEAD,
    OP_NEXT_BUCKET,
    OP_READ_NEXT,
    OP_TAKE_NEXT,
    OP_FOUND,
    OP_DROP_READ,
    OP_DROP_WRITE,
    OP_CARVE_ALLOC,
    OP_MARK_SETUP,
    OP_MARK,
    OP_ALLOC_USED,
    OP_FREE_SETUP,
    OP_READ_INFO,
    OP_CHECK_STEP,
    OP_CLEAR_PAGE,
    OP_FREE_USED,
    OP_READ_BUDDY,
    OP_MERGE_ADV,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                ord_bad;
    logic                range_ok;
    logic                p_nil;
    logic                p_aligned;
    logic                lvl_top;
    logic                buddy_in_range;
    logic                merge_ok;
    logic                info_map;
    logic                len_zero;
    logic                len_one;
    logic                sweep_last;
  } stat_t;

endpackage

// File: rtl/core/bpa_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bpa_ctrl.sv
`timescale 1ns / 1ps
// controller state machine of the buddy page allocator
// depends on bpa_pkg

module bpa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  bpa_pkg::stat_t stat,
  output bpa_pkg::cmd_t  cmd
);
  import bpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SWEEP, S_CV_INIT, S_CV_TEST, S_PUSH1, S_PUSH2,
    S_AL_START, S_AL_HEAD, S_AL_TEST, S_AL_NEXT, S_DROP_RD, S_DROP_WR,
    S_AL_CARVE, S_MARK_SETUP, S_MARK, S_AL_USED, S_FR_START, S_FR_RD,
    S_FR_CHK, S_FR_CLR_SETUP, S_FR_CLR, S_FR_USED, S_MG_TEST, S_MG_CHK,
    S_MG_ADV, S_DONE
  } state_t;

  state_t              state, state_next;
  logic [STATUS_W-1:0] res_code, res_code_next;
  logic                init_flag, init_flag_next;
  logic                rsp_set;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    res_code_next  = res_code;
    init_flag_next = init_flag;
    rsp_set        = 1'b0;
    cmd.op         = OP_IDLE;
    cmd.res_status = res_code;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_LATCH;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.action)
          ACT_INIT: begin
            cmd.op         = OP_CLEAR_START;
            init_flag_next = 1'b1;
            state_next     = S_SWEEP;
          end
          ACT_ALLOC: state_next = S_AL_START;
          ACT_FREE:  state_next = S_FR_START;
          default: begin
            res_code_next = ST_OK;
            state_next    = S_DONE;
          end
        endcase
      end
      S_SWEEP: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) begin
          init_flag_next = 1'b0;
          state_next     = init_flag ? S_CV_INIT : S_IDLE;
        end
      end
      S_CV_INIT: begin
        cmd.op     = OP_CARVE_INIT;
        state_next = S_CV_TEST;
      end
      S_CV_TEST: begin
        if (stat.len_zero) begin
          if (stat.action == ACT_ALLOC) begin
            state_next = S_MARK_SETUP;
          end else begin
            res_code_next = ST_OK;
            state_next    = S_DONE;
          end
        end else begin
          cmd.op     = OP_CARVE_LVL;
          state_next = S_PUSH1;
        end
      end
      S_PUSH1: begin
        cmd.op     = OP_PUSH1;
        state_next = S_PUSH2;
      end
      S_PUSH2: begin
        if (stat.action == ACT_FREE) begin
          cmd.op        = OP_PUSH2;
          res_code_next = ST_OK;
          state_next    = S_DONE;
        end else begin
          cmd.op     = OP_PUSH2_ADV;
          state_next = S_CV_TEST;
        end
      end
      S_AL_START: begin
        cmd.op = OP_ALLOC_START;
        if (stat.ord_bad) begin
          res_code_next = ST_NO_FIT;
          state_next    = S_DONE;
        end else begin
          state_next = S_AL_HEAD;
        end
      end
      S_AL_HEAD: begin
        cmd.op     = OP_LOAD_HEAD;
        state_next = S_AL_TEST;
      end
      S_AL_TEST: begin
        if (stat.p_nil) begin
          if (stat.lvl_top) begin
            res_code_next = ST_NO_FIT;
            state_next    = S_DONE;
          end else begin
            cmd.op     = OP_NEXT_BUCKET;
            state_next = S_AL_HEAD;
          end
        end else if (stat.p_aligned) begin
          cmd.op     = OP_FOUND;
          state_next = S_DROP_RD;
        end else begin
          cmd.op     = OP_READ_NEXT;
          state_next = S_AL_NEXT;
        end
      end
      S_AL_NEXT: begin
        cmd.op     = OP_TAKE_NEXT;
        state_next = S_AL_TEST;
      end
      S_DROP_RD: begin
        cmd.op     = OP_DROP_READ;
        state_next = S_DROP_WR;
      end
      S_DROP_WR: begin
        cmd.op     = OP_DROP_WRITE;
        state_next = (stat.action == ACT_ALLOC) ? S_AL_CARVE : S_MG_ADV;
      end
      S_AL_CARVE: begin
        cmd.op     = OP_CARVE_ALLOC;
        state_next = S_CV_TEST;
      end
      S_MARK_SETUP: begin
        cmd.op     = OP_MARK_SETUP;
        state_next = S_MARK;
      end
      S_MARK: begin
        cmd.op = OP_MARK;
        if (stat.len_one) begin
          state_next = S_AL_USED;
        end
      end
      S_AL_USED: begin
        cmd.op        = OP_ALLOC_USED;
        res_code_next = ST_OK;
        state_next    = S_DONE;
      end
      S_FR_START: begin
        cmd.op = OP_FREE_SETUP;
        if (stat.range_ok) begin
          state_next = S_FR_RD;
        end else begin
          res_code_next = ST_RANGE;
          state_next    = S_DONE;
        end
      end
      S_FR_RD: begin
        cmd.op     = OP_READ_INFO;
        state_next = S_FR_CHK;
      end
      S_FR_CHK: begin
        cmd.op = OP_CHECK_STEP;
        if (!stat.info_map) begin
          // a page of the chunk is already free
          res_code_next = ST_RANGE;
          state_next    = S_DONE;
        end else if (stat.len_one) begin
          state_next = S_FR_CLR_SETUP;
        end else begin
          state_next = S_FR_RD;
        end
      end
      S_FR_CLR_SETUP: begin
        cmd.op     = OP_FREE_SETUP;
        state_next = S_FR_CLR;
      end
      S_FR_CLR: begin
        cmd.op = OP_CLEAR_PAGE;
        if (stat.len_one) begin
          state_next = S_FR_USED;
        end
      end
      S_FR_USED: begin
        cmd.op     = OP_FREE_USED;
        state_next = S_MG_TEST;
      end
      S_MG_TEST: begin
        if (stat.lvl_top || !stat.buddy_in_range) begin
          state_next = S_PUSH1;
        end else begin
          cmd.op     = OP_READ_BUDDY;
          state_next = S_MG_CHK;
        end
      end
      S_MG_CHK: begin
        state_next = stat.merge_ok ? S_DROP_RD : S_PUSH1;
      end
      S_MG_ADV: begin
        cmd.op     = OP_MERGE_ADV;
        state_next = S_MG_TEST;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.op     = OP_RESULT;
          rsp_set    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // clearing pass over the page memory follows reset
      state     <= S_SWEEP;
      res_code  <= ST_OK;
      init_flag <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_code  <= res_code_next;
      init_flag <= init_flag_next;
      if (rsp_set) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/bpa_datapath.sv
`timescale 1ns / 1ps
// datapath of the buddy page allocator: page memories, list heads, counters
// depends on bpa_pkg and bpa_ram

module bpa_datapath #(
  parameter int NUM_LEVELS      = bpa_pkg::NUM_LEVELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]       cfg_data,
  input  bpa_pkg::req_t                   req,
  output bpa_pkg::rsp_t                   rsp,
  input  bpa_pkg::cmd_t                   cmd,
  output bpa_pkg::stat_t                  stat
);
  import bpa_pkg::*;

  localparam int AW    = PAGE_INDEX_BITS_DEF;
  localparam int DEPTH = 1 << AW;
  localparam int PW    = AW + 1;
  localparam int LW    = $clog2(NUM_LEVELS);
  localparam int CW    = (PW > NUM_LEVELS) ? PW : NUM_LEVELS;
  localparam int EW    = (PW > COUNT_W) ? PW : COUNT_W;
  localparam int IW    = LW + 2;
  localparam int TW    = $clog2(CW) + 1;
  localparam logic [PW-1:0] NIL = PW'(1) << AW;

  logic [PAGE_W-1:0]   cfg_first;
  logic [CFG_W-1:0]    cfg_end;
  logic [PW-1:0]       loaded_first, loaded_end, used;
  logic [PW-1:0]       p, len, found, tgt, h_reg, page_r;
  logic [AW-1:0]       cnt;
  logic [LW-1:0]       lvl;
  logic [ACTION_W-1:0] act_r;
  logic [ORDER_W-1:0]  ord_r, al_r;
  logic [PW-1:0]       heads [NUM_LEVELS];

  logic [CW-1:0]  pow_ord, pow_lvl, buddy;
  logic [CW:0]    free_end;
  logic [PW-1:0]  amask;
  logic [EW-1:0]  f_cl, e_cl;
  logic [TW-1:0]  tz, msb, cl;
  logic           sweep_in;
  logic [PW-1:0]  lnk_next, lnk_prev;

  logic           info_we;
  logic [AW-1:0]  info_waddr, info_raddr;
  logic [IW-1:0]  info_wdata, info_rdata;
  logic           next_we, prev_we;
  logic [AW-1:0]  next_waddr, next_raddr, prev_waddr, prev_raddr;
  logic [PW-1:0]  next_wdata, prev_wdata;

  // per-page word: allocated bit, free head bit, chunk level
  bpa_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_info (
    .clk(clk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
    .raddr(info_raddr), .rdata(info_rdata)
  );

  bpa_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(next_raddr), .rdata(lnk_next)
  );

  bpa_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(prev_raddr), .rdata(lnk_prev)
  );

  assign pow_ord  = CW'(1) << ord_r;
  assign pow_lvl  = CW'(1) << lvl;
  assign buddy    = CW'(p) ^ pow_lvl;
  assign free_end = (CW+1)'(page_r) + (CW+1)'(pow_ord);
  assign f_cl     = (EW'(cfg_first) < EW'(NIL)) ? EW'(cfg_first) : EW'(NIL);
  assign e_cl     = (EW'(cfg_end) < EW'(NIL)) ? EW'(cfg_end) : EW'(NIL);
  assign sweep_in = (PW'(cnt) >= loaded_first) && (PW'(cnt) < loaded_end);

  always_comb begin
    for (int j = 0; j < PW; j++) begin
      amask[j] = (al_r > ORDER_W'(j));
    end
  end

  // carve size: lowest set bit of the address against highest set bit of the length
  always_comb begin
    tz = TW'(NUM_LEVELS - 1);
    for (int j = PW - 1; j >= 0; j--) begin
      if (p[j]) tz = TW'(j);
    end
    msb = '0;
    for (int j = 0; j < PW; j++) begin
      if (len[j]) msb = TW'(j);
    end
    cl = (tz < msb) ? tz : msb;
    if (cl > TW'(NUM_LEVELS - 1)) cl = TW'(NUM_LEVELS - 1);
  end

  always_comb begin
    info_we    = 1'b0;
    info_waddr = p[AW-1:0];
    info_wdata = '0;
    info_raddr = p[AW-1:0];
    case (cmd.op)
      OP_SWEEP: begin
        info_we    = 1'b1;
        info_waddr = cnt;
        info_wdata = {!sweep_in, 1'b0, {LW{1'b0}}};
      end
      OP_PUSH1: begin
        info_we    = 1'b1;
        info_wdata = {1'b0, 1'b1, lvl};
      end
      OP_DROP_WRITE: begin
        info_we    = 1'b1;
        info_waddr = tgt[AW-1:0];
        info_wdata = {1'b0, 1'b0, lvl};
      end
      OP_MARK: begin
        info_we    = 1'b1;
        info_wdata = {1'b1, 1'b0, {LW{1'b0}}};
      end
      OP_CLEAR_PAGE: begin
        info_we = 1'b1;
      end
      OP_READ_BUDDY: info_raddr = buddy[AW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    next_we    = 1'b0;
    next_waddr = p[AW-1:0];
    next_wdata = heads[lvl];
    next_raddr = (cmd.op == OP_DROP_READ) ? tgt[AW-1:0] : p[AW-1:0];
    prev_we    = 1'b0;
    prev_waddr = p[AW-1:0];
    prev_wdata = NIL;
    prev_raddr = tgt[AW-1:0];
    case (cmd.op)
      OP_PUSH1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end
      OP_PUSH2, OP_PUSH2_ADV: begin
        prev_we    = (h_reg != NIL);
        prev_waddr = h_reg[AW-1:0];
        prev_wdata = p;
      end
      OP_DROP_WRITE: begin
        next_we    = (lnk_prev != NIL);
        next_waddr = lnk_prev[AW-1:0];
        next_wdata = lnk_next;
        prev_we    = (lnk_next != NIL);
        prev_waddr = lnk_next[AW-1:0];
        prev_wdata = lnk_prev;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.action         = act_r;
    stat.ord_bad        = (ord_r >= ORDER_W'(NUM_LEVELS));
    stat.range_ok       = !stat.ord_bad && (page_r >= loaded_first) &&
                          (free_end <= (CW+1)'(loaded_end));
    stat.p_nil          = (p == NIL);
    stat.p_aligned      = ((p & amask) == '0);
    stat.lvl_top        = (lvl >= LW'(NUM_LEVELS - 1));
    stat.buddy_in_range = (buddy >= CW'(loaded_first)) && (buddy < CW'(loaded_end));
    stat.merge_ok       = !info_rdata[IW-1] && info_rdata[IW-2] &&
                          (info_rdata[LW-1:0] == lvl);
    stat.info_map       = info_rdata[IW-1];
    stat.len_zero       = (len == '0);
    stat.len_one        = (len == PW'(1));
    stat.sweep_last     = (cnt == {AW{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_first    <= '0;
      cfg_end      <= CFG_W'(1) << PAGE_W;
      loaded_first <= '0;
      loaded_end   <= '0;
      used         <= '0;
      cnt          <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        heads[l] <= NIL;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_REGION_FIRST: cfg_first <= cfg_data[PAGE_W-1:0];
          CFG_REGION_END:   cfg_end   <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LATCH: begin
          act_r  <= req.action;
          ord_r  <= req.order;
          al_r   <= req.align_log2;
          page_r <= PW'(req.page);
        end
        OP_CLEAR_START: begin
          cnt  <= '0;
          used <= '0;
          for (int l = 0; l < NUM_LEVELS; l++) begin
            heads[l] <= NIL;
          end
          if (e_cl > f_cl) begin
            loaded_first <= PW'(f_cl);
            loaded_end   <= PW'(e_cl);
          end else begin
            loaded_first <= '0;
            loaded_end   <= '0;
          end
        end
        OP_SWEEP:      cnt <= cnt + AW'(1);
        OP_CARVE_INIT: begin
          p   <= loaded_first;
          len <= loaded_end - loaded_first;
        end
        OP_CARVE_LVL: lvl <= LW'(cl);
        OP_PUSH1: begin
          heads[lvl] <= p;
          h_reg      <= heads[lvl];
        end
        OP_PUSH2_ADV: begin
          p   <= p + PW'(pow_lvl);
          len <= len - PW'(pow_lvl);
        end
        OP_ALLOC_START: lvl <= LW'(ord_r);
        OP_LOAD_HEAD:   p   <= heads[lvl];
        OP_NEXT_BUCKET: lvl <= lvl + LW'(1);
        OP_TAKE_NEXT:   p   <= lnk_next;
        OP_FOUND: begin
          found <= p;
          tgt   <= p;
        end
        OP_DROP_WRITE: begin
          if (lnk_prev == NIL) heads[lvl] <= lnk_next;
        end
        OP_CARVE_ALLOC: begin
          p   <= found + PW'(pow_ord);
          len <= PW'(pow_lvl) - PW'(pow_ord);
        end
        OP_MARK_SETUP: begin
          p   <= found;
          len <= PW'(pow_ord);
        end
        OP_MARK, OP_CHECK_STEP, OP_CLEAR_PAGE: begin
          p   <= p + PW'(1);
          len <= len - PW'(1);
        end
        OP_ALLOC_USED: used <= used + PW'(pow_ord);
        OP_FREE_SETUP: begin
          p   <= page_r;
          len <= PW'(pow_ord);
        end
        OP_FREE_USED: begin
          used <= used - PW'(pow_ord);
          p    <= page_r;
          lvl  <= LW'(ord_r);
        end
        OP_READ_BUDDY: tgt <= PW'(buddy);
        OP_MERGE_ADV: begin
          p   <= p & ~PW'(pow_lvl);
          lvl <= lvl + LW'(1);
        end
        OP_RESULT: begin
          rsp.status       <= cmd.res_status;
          rsp.granted_page <= (cmd.res_status == ST_OK && act_r == ACT_ALLOC) ?
                              PAGE_W'(found) : '0;
          rsp.used_pages   <= COUNT_W'(used);
        end
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/core/buddy_page_allocator_core.sv
`timescale 1ns / 1ps
// top level of the binary buddy page allocator: controller plus datapath
// depends on bpa_pkg, bpa_ctrl, bpa_datapath
//
//  channel   signals                        payload
//  request   req_valid / req_stall          req  (action, order, align_log2, page)
//  response  rsp_valid / rsp_stall          rsp  (status, granted_page, used_pages)
//  config    cfg_write, cfg_index           cfg_data (region first / end page)
//
// one request at a time; allocate searches level by level, passes list entries, carves
// the spare chunks and marks each granted page; free checks and clears each page
// of the chunk and then merges with free buddies step by step; init sweeps the whole
// page memory and then pushes each carved chunk.
// after reset a clearing pass over the page memory runs with req_stall high.
// a finished response waits in its register while the next request is taken.

module buddy_page_allocator_core #(
  parameter int NUM_LEVELS      = bpa_pkg::NUM_LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  bpa_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output bpa_pkg::rsp_t                 rsp
);
  import bpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .stat(stat), .cmd(cmd)
  );

  bpa_datapath #(
    .NUM_LEVELS(NUM_LEVELS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req), .rsp(rsp), .cmd(cmd), .stat(stat)
  );

endmodule

// File: rtl/core/bpa_checker.sv
`timescale 1ns / 1ps
// port-level checks for the buddy page allocator, bound to the top level
// depends on bpa_pkg and buddy_page_allocator_core

module bpa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_write,
  input logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [bpa_pkg::CFG_W-1:0]     cfg_data,
  input logic                          req_valid,
  input logic                          req_stall,
  input bpa_pkg::req_t                 req,
  input logic                          rsp_valid,
  input logic                          rsp_stall,
  input bpa_pkg::rsp_t                 rsp
);
  import bpa_pkg::*;

  // held response stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // clearing pass keeps requests out after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> req_stall)
    else $error("request side open right after reset");

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

  // no page is granted on an error response
  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.granted_page == '0)
    else $error("page granted on an error response");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (.*);

// File: test/tb_buddy_page_allocator_core.sv
`timescale 1ns / 1ps
// testbench for buddy_page_allocator_core: directed and random requests, checked
// against an in-bench buddy allocator predictor; depends on bpa_pkg and the core rtl

module tb_buddy_page_allocator_core;
  import bpa_pkg::*;

  localparam int NPG   = 1 << PAGE_INDEX_BITS_DEF;
  localparam int NLV   = NUM_LEVELS_DEF;
  localparam int NIL   = NPG;
  localparam logic [ACTION_W-1:0] ACT_RSVD = 2'd3;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int LONG_HOLD = 3000;

  typedef struct {
    int page;
    int ord;
  } chunk_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  buddy_page_allocator_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bit         page_taken[NPG];
  logic [4:0] chunk_lvl[NPG];
  bit         free_head[NPG];
  int         link_next[NPG];
  int         link_prev[NPG];
  int         lvl_head[NLV];
  int         used_cnt;
  int         reg_first, reg_end;
  int         live_first, live_end;

  rsp_t   pending_rsp[$];
  chunk_t granted_chunks[$];
  int     errors = 0;
  bit     quiet = 1'b0;
  bit     hold_go = 1'b0;
  longint cycles = 0;

  task automatic report_err(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void push_free(int p, int lvl);
    int h;
    h = lvl_head[lvl];
    chunk_lvl[p] = lvl[4:0];
    free_head[p] = 1'b1;
    link_prev[p] = NIL;
    link_next[p] = h;
    if (h != NIL) link_prev[h] = p;
    lvl_head[lvl] = p;
  endfunction

  function automatic void unlink_free(int p);
    int lvl, n, b;
    lvl = chunk_lvl[p];
    n = link_next[p];
    b = link_prev[p];
    if (b == NIL) lvl_head[lvl] = n;
    else link_next[b] = n;
    if (n != NIL) link_prev[n] = b;
    free_head[p] = 1'b0;
  endfunction

  // split a run of pages into the largest aligned chunks
  function automatic void split_run(int addr, int len);
    int a, r, i;
    while (len != 0) begin
      a = 0;
      r = 0;
      if (addr == 0) a = 31;
      else while (a < 31 && ((addr >> a) & 1) == 0) a++;
      while (r < 31 && (len >> (r + 1)) != 0) r++;
      i = (a < r) ? a : r;
      if (i > NLV - 1) i = NLV - 1;
      push_free(addr, i);
      addr += 1 << i;
      len -= 1 << i;
    end
  endfunction

  function automatic void wipe_state();
    for (int i = 0; i < NPG; i++) begin
      page_taken[i] = 1'b1;
      free_head[i] = 1'b0;
    end
    for (int l = 0; l < NLV; l++) lvl_head[l] = NIL;
    used_cnt = 0;
    live_first = 0;
    live_end = 0;
  endfunction

  function automatic rsp_t buddy_predict(req_t r);
    rsp_t o;
    int ord, al, pg, f, e, found, bucket, p, len, b, sz;
    bit ok;
    longint amask;
    ord = r.order;
    al = r.align_log2;
    pg = r.page;
    o = '0;
    o.status = ST_OK;
    case (r.action)
      ACT_INIT: begin
        f = (reg_first < NPG) ? reg_first : NPG;
        e = (reg_end < NPG) ? reg_end : NPG;
        wipe_state();
        if (e > f) begin
          for (int i = f; i < e; i++) page_taken[i] = 1'b0;
          live_first = f;
          live_end = e;
          split_run(f, e - f);
        end
      end
      ACT_ALLOC: begin
        found = NIL;
        bucket = ord;
        amask = (64'd1 << al) - 1;
        if (ord < NLV) begin
          for (; bucket < NLV; bucket++) begin
            p = lvl_head[bucket];
            while (p != NIL && (longint'(p) & amask) != 0) p = link_next[p];
            if (p != NIL) begin
              found = p;
              break;
            end
          end
        end
        if (found == NIL) o.status = ST_NO_FIT;
        else begin
          len = 1 << ord;
          unlink_free(found);
          split_run(found + len, (1 << bucket) - len);
          for (int i = 0; i < len; i++) page_taken[found + i] = 1'b1;
          used_cnt += len;
          o.granted_page = found[PAGE_W-1:0];
        end
      end
      ACT_FREE: begin
        ok = ord < NLV && pg >= live_first && pg + (1 << (ord < NLV ? ord : 0)) <= live_end;
        if (ok) begin
          len = 1 << ord;
          for (int k = 0; k < len; k++) if (!page_taken[pg + k]) ok = 1'b0;
        end
        if (!ok) o.status = ST_RANGE;
        else begin
          p = pg;
          for (int k = 0; k < len; k++) page_taken[p + k] = 1'b0;
          used_cnt -= len;
          while (ord < NLV - 1) begin
            sz = 1 << ord;
            b = (p & sz) ? p - sz : p + sz;
            if (b < live_first || b >= live_end || page_taken[b] || !free_head[b] ||
                chunk_lvl[b] != ord)
              break;
            unlink_free(b);
            free_head[p] = 1'b0;
            if (p & sz) p = b;
            ord++;
          end
          push_free(p, ord);
        end
      end
      default: ;
    endcase
    o.used_pages = used_cnt[COUNT_W-1:0];
    return o;
  endfunction

  // request side: caller is always just past a rising edge
  task automatic send_req(input req_t r);
    rsp_t x;
    chunk_t c;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    x = buddy_predict(r);
    pending_rsp.push_back(x);
    if (r.action == ACT_ALLOC && x.status == ST_OK) begin
      c.page = x.granted_page;
      c.ord = r.order;
      granted_chunks.push_back(c);
    end
    if (r.action == ACT_INIT) granted_chunks.delete();
  endtask

  task automatic send_fields(input logic [1:0] act, input int ord, input int al,
                             input int pg);
    req_t r;
    r.action = act;
    r.order = ord[ORDER_W-1:0];
    r.align_log2 = al[ORDER_W-1:0];
    r.page = pg[PAGE_W-1:0];
    send_req(r);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_region(input int first, input int last);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= CFG_REGION_FIRST;
    cfg_data <= first[CFG_W-1:0];
    @(posedge clk);
    reg_first = first & 16'hFFFF;
    cfg_index <= CFG_REGION_END;
    cfg_data <= last[CFG_W-1:0];
    @(posedge clk);
    reg_end = last & 17'h1FFFF;
    cfg_write <= 1'b0;
  endtask

  task automatic send_random();
    int sel, ord, al, idx;
    chunk_t c;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      ord = $urandom_range(0, 99);
      ord = ord < 80 ? $urandom_range(0, 3) : ord < 95 ? $urandom_range(4, 6) :
            $urandom_range(17, 31);
      al = $urandom_range(0, 9);
      al = al < 6 ? 0 : al < 9 ? $urandom_range(0, ord + 2) : $urandom_range(16, 31);
      send_fields(ACT_ALLOC, ord, al, $urandom_range(0, NPG - 1));
    end else if (sel < 90 && granted_chunks.size() != 0) begin
      idx = $urandom_range(0, granted_chunks.size() - 1);
      c = granted_chunks[idx];
      granted_chunks.delete(idx);
      send_fields(ACT_FREE, c.ord, $urandom_range(0, 31), c.page);
    end else if (sel < 97) begin
      // stray free: small sizes or an order that is turned away at once
      ord = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(17, 31);
      send_fields(ACT_FREE, ord, $urandom_range(0, 31), $urandom_range(0, NPG - 1));
    end else
      send_fields(ACT_RSVD, $urandom_range(0, 31), $urandom_range(0, 31),
                  $urandom_range(0, NPG - 1));
  endtask

  task automatic test_before_init();
    send_fields(ACT_ALLOC, 0, 0, 0);
    send_fields(ACT_FREE, 0, 0, 0);
    send_fields(ACT_RSVD, 31, 31, 16'hFFFF);
  endtask

  task automatic test_directed_full();
    int g;
    set_region(0, 65536);
    send_fields(ACT_INIT, 0, 0, 0);
    send_fields(ACT_ALLOC, 16, 0, 0);
    send_fields(ACT_ALLOC, 0, 0, 0);
    send_fields(ACT_FREE, 16, 0, 0);
    send_fields(ACT_ALLOC, 0, 16, 0);
    send_fields(ACT_ALLOC, 0, 31, 0);
    send_fields(ACT_ALLOC, 17, 0, 0);
    send_fields(ACT_ALLOC, 31, 0, 0);
    send_fields(ACT_FREE, 0, 0, 0);
    send_fields(ACT_FREE, 0, 0, 0);
    send_fields(ACT_FREE, 20, 0, 0);
    send_fields(ACT_ALLOC, 2, 2, 0);
    g = granted_chunks[$].page;
    // unaligned free inside a granted chunk, then its neighbours
    send_fields(ACT_FREE, 0, 0, g + 1);
    send_fields(ACT_FREE, 1, 0, g + 2);
    send_fields(ACT_FREE, 0, 0, g);
    send_fields(ACT_ALLOC, 3, 0, 0);
    send_fields(ACT_INIT, 0, 0, 0);
    send_fields(ACT_ALLOC, 4, 4, 0);
  endtask

  task automatic test_edge_regions();
    set_region(5, 5);
    send_fields(ACT_INIT, 0, 0, 0);
    send_fields(ACT_ALLOC, 0, 0, 0);
    send_fields(ACT_FREE, 0, 0, 5);
    set_region(900, 10);
    send_fields(ACT_INIT, 0, 0, 0);
    send_fields(ACT_ALLOC, 0, 0, 0);
    set_region(65535, 65536);
    send_fields(ACT_INIT, 0, 0, 0);
    send_fields(ACT_ALLOC, 0, 0, 0);
    send_fields(ACT_ALLOC, 0, 0, 0);
    send_fields(ACT_FREE, 0, 0, 65535);
    send_fields(ACT_FREE, 1, 0, 65535);
  endtask

  task automatic test_small_region();
    set_region(100, 1000);
    send_fields(ACT_INIT, 0, 0, 0);
    repeat (500) send_random();
  endtask

  task automatic test_clamped_region();
    set_region(16'hFF00, 17'h1FFFF);
    send_fields(ACT_INIT, 0, 0, 0);
    repeat (300) send_random();
  endtask

  task automatic test_backpressure();
    hold_go = 1'b1;
    repeat (12) send_random();
    wait_drained();
  endtask

  task automatic test_full_region_burst();
    set_region(0, 65536);
    send_fields(ACT_INIT, 0, 0, 0);
    repeat (300) send_random();
    quiet = 1'b1;
    repeat (500) send_random();
  endtask

  // response side stalls
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    rsp_t x;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) report_err("response with nothing expected");
      else begin
        x = pending_rsp.pop_front();
        if (rsp.status !== x.status)
          report_err($sformatf("status %0d want %0d", rsp.status, x.status));
        if (rsp.granted_page !== x.granted_page)
          report_err($sformatf("granted_page %0d want %0d", rsp.granted_page,
                               x.granted_page));
        if (rsp.used_pages !== x.used_pages)
          report_err($sformatf("used_pages %0d want %0d", rsp.used_pages, x.used_pages));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reg_first = 0;
    reg_end = 65536;
    wipe_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    do @(posedge clk); while (req_stall);
    test_before_init();
    test_directed_full();
    test_edge_regions();
    test_small_region();
    test_backpressure();
    test_clamped_region();
    test_full_region_burst();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// File: buddy_page_allocator_core.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_ram.sv
rtl/core/bpa_ctrl.sv
rtl/core/bpa_datapath.sv
rtl/core/buddy_page_allocator_core.sv
rtl/core/bpa_checker.sv
test/tb_buddy_page_allocator_core.sv
